/* hw/rtl/msc_pkg.sv */
// ----------------------------------------------------------------------------
// msc_pkg
// shared types and constants of the mesh packet stream checker
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int BYTE_COUNT_BITS = 33;
  localparam logic [BYTE_COUNT_BITS-1:0] POS_MAX = '1;

  localparam logic [63:0] MAGIC_WORD = 64'h3130_4853_4D49_4D47;
  localparam logic [63:0] HEADER_LEN = 64'd64;

  localparam int ERR_SIZE   = 0;
  localparam int ERR_HDR    = 1;
  localparam int ERR_COUNT  = 2;
  localparam int ERR_LAYOUT = 3;
  localparam int ERR_PAD    = 4;
  localparam int ERR_MESH   = 5;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_SOURCE   = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PKT  = 2'd1,
    ST_BAD_MESH = 2'd2,
    ST_LIMIT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_VERTICES  = 2'd0,
    REG_MAX_TRIANGLES = 2'd1,
    REG_MAX_PKT_BYTES = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  localparam int OUT_TDATA_BITS = 232;
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] index;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
    status_t     status;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic v0;
    rec_t r0;
    logic v1;
    rec_t r1;
  } push_t;

endpackage

/* hw/rtl/msc_core.sv */
// ----------------------------------------------------------------------------
// msc_core
// per-byte header, layout and payload checks with record generation
// ----------------------------------------------------------------------------
module msc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  output msc_pkg::push_t      push
);
  import msc_pkg::*;

  logic [31:0] max_vert_r, max_tri_r, max_pkt_r;
  logic [BYTE_COUNT_BITS-1:0] pos_r, pos_nxt, size;
  logic [63:0] shift_r, shift_nxt;
  logic [63:0] hs_r [6];
  logic [63:0] hs_nxt [6];
  logic [63:0] coord_r [2];
  logic [63:0] coord_nxt [2];
  logic [31:0] ihold_r [2];
  logic [31:0] ihold_nxt [2];
  logic [4:0]  cnt_r, cnt_nxt, sub;
  logic [31:0] idx_r, idx_nxt, idx;
  logic [7:0]  flags_r, flags_nxt;
  logic [31:0] vc, tc, v;
  logic [63:0] pos64, w, te, pe, te8;
  rec_t        data_rec, stat_rec;
  logic        data_v;
  status_t     st;

  always_comb begin
    vc = hs_r[1][31:0];
    tc = hs_r[1][63:32];
    size = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
    pos64 = {{(64-BYTE_COUNT_BITS){1'b0}}, pos_r};
    flags_nxt = flags_r;
    if ({{(64-BYTE_COUNT_BITS){1'b0}}, size} > {32'd0, max_pkt_r}) flags_nxt[ERR_SIZE] = 1'b1;
    shift_nxt = {data_byte, shift_r[63:8]};
    w = shift_nxt;
    v = w[63:32];
    pos_nxt = size;
    hs_nxt = hs_r;
    coord_nxt = coord_r;
    ihold_nxt = ihold_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    sub = cnt_r;
    idx = idx_r;
    te = hs_r[3] + {29'd0, tc, 3'b0} + {30'd0, tc, 2'b0};
    te8 = (te + 64'd7) & ~64'd7;
    pe = w + {30'd0, tc, 2'b0};
    data_v = 1'b0;
    data_rec = '0;
    if (pos64 < HEADER_LEN) begin
      if (pos_r[2:0] == 3'd7) begin
        unique case (pos_r[5:3])
          3'd0: if (w != MAGIC_WORD) flags_nxt[ERR_HDR] = 1'b1;
          3'd1: begin
            if (w[15:0] != 16'd1 || w[31:16] != 16'd64 || w[63:33] != '0)
              flags_nxt[ERR_HDR] = 1'b1;
            hs_nxt[2] = {63'd0, w[32]};
          end
          3'd2: hs_nxt[0] = w;
          3'd3: begin
            hs_nxt[1] = w;
            if (w[31:0] == '0 || w[63:32] == '0) flags_nxt[ERR_HDR] = 1'b1;
            if (w[31:0] > max_vert_r || w[63:32] > max_tri_r) flags_nxt[ERR_COUNT] = 1'b1;
          end
          3'd4: if (w != HEADER_LEN) flags_nxt[ERR_HDR] = 1'b1;
          3'd5: hs_nxt[3] = w;
          3'd6: begin
            if (hs_r[3] != HEADER_LEN + {27'd0, vc, 4'b0} + {28'd0, vc, 3'b0}) begin
              flags_nxt[ERR_LAYOUT] = 1'b1;
            end else if (hs_r[2] != '0) begin
              if (w != te8) begin
                flags_nxt[ERR_LAYOUT] = 1'b1;
              end else begin
                if (((pe + 64'd7) & ~64'd7) != hs_r[0]) flags_nxt[ERR_LAYOUT] = 1'b1;
                hs_nxt[2] = te;
                hs_nxt[4] = w;
                hs_nxt[5] = pe;
              end
            end else begin
              if (w != '0) begin
                flags_nxt[ERR_LAYOUT] = 1'b1;
              end else begin
                if (te8 != hs_r[0]) flags_nxt[ERR_LAYOUT] = 1'b1;
                hs_nxt[2] = te;
                hs_nxt[4] = te;
                hs_nxt[5] = te;
              end
            end
          end
          default: if (w != '0) flags_nxt[ERR_HDR] = 1'b1;
        endcase
      end
    end else if (flags_r[ERR_HDR] == 1'b0 && flags_r[ERR_COUNT] == 1'b0 &&
                 flags_r[ERR_LAYOUT] == 1'b0 && pos64 < hs_r[0]) begin
      if (pos64 < hs_r[3]) begin
        if (pos64 == HEADER_LEN) begin
          sub = '0;
          idx = '0;
        end
        cnt_nxt = (sub == 5'd23) ? 5'd0 : sub + 5'd1;
        idx_nxt = (sub == 5'd23) ? idx + 32'd1 : idx;
        if (sub[2:0] == 3'd7) begin
          if (w[62:52] == 11'h7FF) flags_nxt[ERR_MESH] = 1'b1;
          if (sub[4:3] != 2'd2) begin
            coord_nxt[sub[3]] = w;
          end else if (flags_nxt == '0) begin
            data_v = 1'b1;
            data_rec = '{KIND_VERTEX, idx, coord_r[0], coord_r[1], w, ST_OK, 1'b0};
          end
        end
      end else if (pos64 < hs_r[2]) begin
        if (pos64 == hs_r[3]) begin
          sub = '0;
          idx = '0;
        end
        cnt_nxt = (sub == 5'd11) ? 5'd0 : sub + 5'd1;
        idx_nxt = (sub == 5'd11) ? idx + 32'd1 : idx;
        if (sub[1:0] == 2'd3) begin
          if (v >= vc) flags_nxt[ERR_MESH] = 1'b1;
          if (sub[3:2] != 2'd2) begin
            ihold_nxt[sub[2]] = v;
          end else begin
            if (ihold_r[0] == ihold_r[1] || ihold_r[1] == v || v == ihold_r[0])
              flags_nxt[ERR_MESH] = 1'b1;
            if (flags_nxt == '0) begin
              data_v = 1'b1;
              data_rec = '{KIND_TRIANGLE, idx, {32'd0, ihold_r[0]}, {32'd0, ihold_r[1]},
                           {32'd0, v}, ST_OK, 1'b0};
            end
          end
        end
      end else if (pos64 >= hs_r[4] && pos64 < hs_r[5]) begin
        if (pos64 == hs_r[4]) begin
          sub = '0;
          idx = '0;
        end
        cnt_nxt = (sub[1:0] == 2'd3) ? 5'd0 : sub + 5'd1;
        idx_nxt = (sub[1:0] == 2'd3) ? idx + 32'd1 : idx;
        if (sub[1:0] == 2'd3 && flags_nxt == '0) begin
          data_v = 1'b1;
          data_rec = '{KIND_SOURCE, idx, {32'd0, v}, 64'd0, 64'd0, ST_OK, 1'b0};
        end
      end else if (data_byte != 8'd0) begin
        flags_nxt[ERR_PAD] = 1'b1;
      end
    end

    priority if (flags_nxt[ERR_SIZE]) st = ST_LIMIT;
    else if ({{(64-BYTE_COUNT_BITS){1'b0}}, size} < HEADER_LEN) st = ST_BAD_PKT;
    else if (flags_nxt[ERR_HDR] || {{(64-BYTE_COUNT_BITS){1'b0}}, size} != hs_r[0])
      st = ST_BAD_PKT;
    else if (flags_nxt[ERR_COUNT]) st = ST_LIMIT;
    else if (flags_nxt[ERR_LAYOUT] || flags_nxt[ERR_PAD]) st = ST_BAD_PKT;
    else if (flags_nxt[ERR_MESH]) st = ST_BAD_MESH;
    else st = ST_OK;
    stat_rec = '{KIND_STATUS, 32'd0, 64'd0, 64'd0, 64'd0, st, 1'b1};

    push = '0;
    if (acc) begin
      if (data_v) begin
        push.v0 = 1'b1;
        push.r0 = data_rec;
        push.v1 = last_byte;
        push.r1 = stat_rec;
      end else begin
        push.v0 = last_byte;
        push.r0 = stat_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vert_r <= '1;
      max_tri_r  <= '1;
      max_pkt_r  <= 32'hFFFF_FFF8;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_VERTICES:  max_vert_r <= cfg_wdata;
        REG_MAX_TRIANGLES: max_tri_r  <= cfg_wdata;
        REG_MAX_PKT_BYTES: max_pkt_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last_byte)) begin
      pos_r   <= '0;
      shift_r <= '0;
      hs_r    <= '{default: '0};
      cnt_r   <= '0;
      idx_r   <= '0;
      flags_r <= '0;
    end else if (acc) begin
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      hs_r    <= hs_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      coord_r <= coord_nxt;
      ihold_r <= ihold_nxt;
    end
  end

endmodule

/* hw/rtl/msc_out_fifo.sv */
// ----------------------------------------------------------------------------
// msc_out_fifo
// small record queue taking up to two records per cycle
// ----------------------------------------------------------------------------
module msc_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  msc_pkg::push_t push,
  output logic           room2,
  output logic           rd_valid,
  input  logic           rd_ready,
  output msc_pkg::rec_t  rd_rec
);
  import msc_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  rec_t          mem_r [FIFO_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          pop;
  logic [AW:0]   n_push;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = cnt_r != '0;
  assign rd_rec   = mem_r[rp_r];
  assign room2    = cnt_r <= (AW+1)'(FIFO_DEPTH - 2);
  assign n_push   = (AW+1)'(push.v0) + (AW+1)'(push.v1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_push[AW-1:0];
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + n_push - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wp_r] <= push.r0;
    if (push.v1) mem_r[wp_r + 1'b1] <= push.r1;
  end

endmodule

/* hw/rtl/mesh_packet_stream_checker_unit.sv */
// ----------------------------------------------------------------------------
// mesh_packet_stream_checker_unit
// streaming checker for mesh packets with vertex, triangle and source records
// ----------------------------------------------------------------------------
// One packet byte is taken per cycle while in_tready is high; each byte is
// checked and turned into at most two records (a payload record and, on the
// final byte, the status) in the cycle it is accepted. Records are written
// into a four-entry queue and leave it one per cycle while out_tready is high;
// in_tready drops only while fewer than two queue entries are free.
module mesh_packet_stream_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // record_index, word_a, word_b, word_c, status_code, zero fill
  output logic [msc_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  output logic [1:0]  out_tuser,  // record_kind
  output logic        out_tlast,  // last_result
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import msc_pkg::*;

  logic  acc;
  push_t push;
  rec_t  rec;

  assign acc = in_tvalid && in_tready;

  msc_core u_core (
    .clk, .rst_n, .acc,
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .cfg_we, .cfg_index, .cfg_wdata,
    .push
  );

  msc_out_fifo u_fifo (
    .clk, .rst_n, .push,
    .room2    (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_rec   (rec)
  );

  assign out_tdata = {6'd0, rec.status, rec.word_c, rec.word_b, rec.word_a, rec.index};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.last;

endmodule

/* hw/rtl/msc_checker.sv */
// ----------------------------------------------------------------------------
// msc_checker
// port-level checks on the record stream of the checker unit
// ----------------------------------------------------------------------------
module msc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic [231:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  import msc_pkg::*;

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == KIND_STATUS)))
    else $error("last flag not tied to status record");

  a_data_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_STATUS) |-> (out_tdata[225:224] == ST_OK))
    else $error("payload record carries a status");

  a_status_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_STATUS) |-> (out_tdata[31:0] == '0))
    else $error("status record with nonzero index");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("records present after reset");

endmodule

bind mesh_packet_stream_checker_unit msc_checker u_msc_checker (
  .clk, .rst_n, .out_tvalid, .out_tdata, .out_tuser, .out_tlast
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// mesh packet stream checker: built packets, bad headers and mesh faults,
// records checked against a local packet predictor under random back-pressure
// ----------------------------------------------------------------------------
module testbench;
  import msc_pkg::*;

  typedef enum int {
    F_NONE, F_MAGIC, F_VERSION, F_FLAGS, F_RESERVED, F_ZERO_CNT, F_HUGE_CNT,
    F_LAYOUT, F_PAD, F_NAN, F_BAD_IDX, F_DUP_IDX, F_SHORT, F_LONG, F_NOISE
  } fault_t;

  typedef struct {
    int     vc;
    int     tc;
    bit     src;
    fault_t flt;
    bit     chk;
    status_t st;
  } pkt_row_t;

  localparam int ROWS = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  pkt_row_t pkt_tab [ROWS] = '{
    '{3, 1, 0, F_NONE,     1, ST_OK},
    '{4, 2, 1, F_NONE,     1, ST_OK},
    '{3, 1, 1, F_MAGIC,    1, ST_BAD_PKT},
    '{3, 1, 0, F_VERSION,  1, ST_BAD_PKT},
    '{3, 1, 1, F_FLAGS,    1, ST_BAD_PKT},
    '{3, 1, 0, F_RESERVED, 1, ST_BAD_PKT},
    '{3, 1, 0, F_ZERO_CNT, 1, ST_BAD_PKT},
    '{3, 1, 0, F_HUGE_CNT, 0, ST_BAD_PKT},
    '{3, 2, 1, F_LAYOUT,   1, ST_BAD_PKT},
    '{3, 1, 1, F_PAD,      1, ST_BAD_PKT},
    '{3, 1, 0, F_NAN,      1, ST_BAD_MESH},
    '{4, 2, 0, F_BAD_IDX,  1, ST_BAD_MESH},
    '{3, 2, 1, F_DUP_IDX,  1, ST_BAD_MESH},
    '{3, 1, 0, F_SHORT,    1, ST_BAD_PKT},
    '{3, 1, 1, F_LONG,     1, ST_BAD_PKT},
    '{2, 1, 0, F_NOISE,    0, ST_BAD_PKT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_NONE;
  logic [31:0] cfg_wdata = '0;

  mesh_packet_stream_checker_unit i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  bit [63:0] lim_vert, lim_tri, lim_bytes;
  bit [BYTE_COUNT_BITS-1:0] byte_pos;
  bit [63:0] shift_word;
  bit [63:0] hdr [6];
  bit [63:0] coord [2];
  bit [31:0] vidx [2];
  bit [31:0] rec_count;
  bit [7:0]  err_bits;
  status_t   last_status;

  rec_t   record_q [$];
  byte    pkt_bytes [$];
  int     mismatches = 0;
  int     send_idle = 0;
  int     recv_stall = 0;
  int     quiet_cycles = 0;

  function automatic void packet_clear();
    byte_pos = '0;
    shift_word = '0;
    foreach (hdr[i]) hdr[i] = '0;
    coord = '{64'd0, 64'd0};
    vidx = '{32'd0, 32'd0};
    rec_count = '0;
    err_bits = '0;
  endfunction

  function automatic void push_record(kind_t k, bit [31:0] idx, bit [63:0] a, bit [63:0] b,
                                      bit [63:0] c, status_t st, bit last);
    rec_t r;
    r.kind = k;
    r.index = idx;
    r.word_a = a;
    r.word_b = b;
    r.word_c = c;
    r.status = st;
    r.last = last;
    record_q = {record_q, r};
  endfunction

  function automatic void add_byte(byte b);
    pkt_bytes = {pkt_bytes, b};
  endfunction

  function automatic bit [63:0] round8(bit [63:0] v);
    return (v + 64'd7) & ~64'd7;
  endfunction

  function automatic void header_word(int k, bit [63:0] w);
    bit [63:0] vc, tc, te, pe, start;
    vc = {32'd0, hdr[1][31:0]};
    tc = {32'd0, hdr[1][63:32]};
    case (k)
      0: if (w != MAGIC_WORD) err_bits[ERR_HDR] = 1'b1;
      1: begin
        if (w[15:0] != 16'd1 || w[31:16] != 16'd64 || w[63:33] != '0)
          err_bits[ERR_HDR] = 1'b1;
        hdr[2] = {63'd0, w[32]};
      end
      2: hdr[0] = w;
      3: begin
        hdr[1] = w;
        if (w[31:0] == '0 || w[63:32] == '0) err_bits[ERR_HDR] = 1'b1;
        if ({32'd0, w[31:0]} > lim_vert || {32'd0, w[63:32]} > lim_tri)
          err_bits[ERR_COUNT] = 1'b1;
      end
      4: if (w != HEADER_LEN) err_bits[ERR_HDR] = 1'b1;
      5: hdr[3] = w;
      6: begin
        if (hdr[3] != HEADER_LEN + 64'd24 * vc) begin
          err_bits[ERR_LAYOUT] = 1'b1;
          return;
        end
        te = hdr[3] + 64'd12 * tc;
        if (hdr[2] != 0) begin
          if (w != round8(te)) begin
            err_bits[ERR_LAYOUT] = 1'b1;
            return;
          end
          start = w;
          pe = w + 64'd4 * tc;
        end else begin
          if (w != 0) begin
            err_bits[ERR_LAYOUT] = 1'b1;
            return;
          end
          start = te;
          pe = te;
        end
        if (round8(pe) != hdr[0]) err_bits[ERR_LAYOUT] = 1'b1;
        hdr[2] = te;
        hdr[4] = start;
        hdr[5] = pe;
      end
      default: if (w != 0) err_bits[ERR_HDR] = 1'b1;
    endcase
  endfunction

  function automatic void payload_byte(bit [63:0] p, bit [7:0] b);
    bit [63:0] rel, r, w;
    bit [31:0] v;
    w = shift_word;
    if (p < hdr[3]) begin
      rel = p - HEADER_LEN;
      r = rel % 24;
      if (r[2:0] != 3'd7) return;
      if (w[62:52] == '1) err_bits[ERR_MESH] = 1'b1;
      if ((r >> 3) < 2) begin
        coord[r >> 3] = w;
        return;
      end
      rec_count = 32'(rel / 24);
      if (err_bits == 0) push_record(KIND_VERTEX, rec_count, coord[0], coord[1], w, ST_OK, 0);
      return;
    end
    if (p < hdr[2]) begin
      rel = p - hdr[3];
      r = rel % 12;
      v = w[63:32];
      if (r[1:0] != 2'd3) return;
      if (v >= hdr[1][31:0]) err_bits[ERR_MESH] = 1'b1;
      if ((r >> 2) < 2) begin
        vidx[r >> 2] = v;
        return;
      end
      if (vidx[0] == vidx[1] || vidx[1] == v || v == vidx[0]) err_bits[ERR_MESH] = 1'b1;
      rec_count = 32'(rel / 12);
      if (err_bits == 0)
        push_record(KIND_TRIANGLE, rec_count, {32'd0, vidx[0]}, {32'd0, vidx[1]},
                    {32'd0, v}, ST_OK, 0);
      return;
    end
    if (p >= hdr[4] && p < hdr[5]) begin
      rel = p - hdr[4];
      if (rel[1:0] != 2'd3) return;
      rec_count = 32'(rel >> 2);
      if (err_bits == 0)
        push_record(KIND_SOURCE, rec_count, {32'd0, w[63:32]}, '0, '0, ST_OK, 0);
      return;
    end
    if (b != 0) err_bits[ERR_PAD] = 1'b1;
  endfunction

  function automatic void predict_byte(bit [7:0] b, bit last);
    bit [63:0] p, sz;
    status_t st;
    p = {31'd0, byte_pos};
    sz = (byte_pos != POS_MAX) ? p + 1 : p;
    byte_pos = sz[BYTE_COUNT_BITS-1:0];
    if (sz > lim_bytes) err_bits[ERR_SIZE] = 1'b1;
    shift_word = {b, shift_word[63:8]};
    if (p < HEADER_LEN) begin
      if (p[2:0] == 3'd7) header_word(int'(p >> 3), shift_word);
    end else if (!err_bits[ERR_HDR] && !err_bits[ERR_COUNT] && !err_bits[ERR_LAYOUT] &&
                 p < hdr[0]) begin
      payload_byte(p, b);
    end
    if (last) begin
      if (sz > lim_bytes) st = ST_LIMIT;
      else if (sz < HEADER_LEN) st = ST_BAD_PKT;
      else if (err_bits[ERR_HDR] || sz != hdr[0]) st = ST_BAD_PKT;
      else if (err_bits[ERR_COUNT]) st = ST_LIMIT;
      else if (err_bits[ERR_LAYOUT] || err_bits[ERR_PAD]) st = ST_BAD_PKT;
      else if (err_bits[ERR_MESH]) st = ST_BAD_MESH;
      else st = ST_OK;
      push_record(KIND_STATUS, '0, '0, '0, '0, st, 1);
      last_status = st;
      packet_clear();
    end
  endfunction

  function automatic void put_word(bit [63:0] w, int nbytes);
    for (int i = 0; i < nbytes; i++) add_byte(byte'(w[8*i +: 8]));
  endfunction

  function automatic void build_packet(int vc, int tc, bit src, fault_t flt);
    bit [63:0] tri_off, te, src_off, pe, plen, w, d;
    int a, b, c, j, n;
    int gaps [$];
    tri_off = 64 + 24 * vc;
    te = tri_off + 12 * tc;
    src_off = src ? round8(te) : 64'd0;
    pe = src ? src_off + 4 * tc : te;
    plen = round8(pe);
    pkt_bytes.delete();
    if (flt == F_NOISE) begin
      n = $urandom_range(1, 90);
      repeat (n) add_byte(byte'($urandom));
      return;
    end
    w = MAGIC_WORD;
    if (flt == F_MAGIC) w[$urandom_range(63)] ^= 1'b1;
    put_word(w, 8);
    w = {31'd0, src, 16'd64, 16'd1};
    if (flt == F_VERSION) w[15:0] = 16'($urandom_range(2, 65535));
    if (flt == F_FLAGS) w[32 + $urandom_range(1, 31)] = 1'b1;
    put_word(w, 8);
    put_word(plen, 8);
    w = {32'(tc), 32'(vc)};
    if (flt == F_ZERO_CNT) begin
      if ($urandom_range(1)) w[31:0] = '0;
      else w[63:32] = '0;
    end
    if (flt == F_HUGE_CNT) w = '1;
    put_word(w, 8);
    put_word(HEADER_LEN, 8);
    w = tri_off;
    if (flt == F_LAYOUT && $urandom_range(1)) w += 8;
    put_word(w, 8);
    w = src_off;
    if (flt == F_LAYOUT && w == tri_off - 0) w ^= 64'd8;
    else if (flt == F_LAYOUT) w ^= 64'd8;
    put_word(w, 8);
    put_word(flt == F_RESERVED ? {$urandom, $urandom} | 64'd1 : 64'd0, 8);
    for (int i = 0; i < 3 * vc; i++) begin
      d = {$urandom, $urandom};
      if (d[62:52] == '1) d[52] = 1'b0;
      put_word(d, 8);
    end
    for (int i = 0; i < tc; i++) begin
      if (vc >= 3) begin
        a = $urandom_range(vc - 1);
        do b = $urandom_range(vc - 1); while (b == a);
        do c = $urandom_range(vc - 1); while (c == a || c == b);
      end else begin
        a = 0;
        b = vc - 1;
        c = 0;
      end
      put_word(a, 4);
      put_word(b, 4);
      put_word(c, 4);
    end
    while (pkt_bytes.size() < int'(src_off)) add_byte(8'd0);
    if (src) for (int i = 0; i < tc; i++) put_word({32'd0, $urandom}, 4);
    while (pkt_bytes.size() < int'(plen)) add_byte(8'd0);
    case (flt)
      F_NAN: begin
        j = 64 + 8 * $urandom_range(3 * vc - 1);
        pkt_bytes[j + 6] |= 8'hF0;
        pkt_bytes[j + 7] |= 8'h7F;
      end
      F_BAD_IDX: begin
        j = int'(tri_off) + 4 * $urandom_range(3 * tc - 1);
        w = $urandom_range(1) ? 64'hFFFF_FFFF : 64'(vc + $urandom_range(0, 9));
        for (int i = 0; i < 4; i++) pkt_bytes[j + i] = byte'(w[8*i +: 8]);
      end
      F_DUP_IDX: begin
        j = int'(tri_off) + 12 * $urandom_range(tc - 1);
        n = 4 * $urandom_range(1, 2);
        for (int i = 0; i < 4; i++) pkt_bytes[j + n + i] = pkt_bytes[j + i];
      end
      F_PAD: begin
        if (src) for (int i = int'(te); i < int'(src_off); i++) gaps = {gaps, i};
        for (int i = int'(pe); i < int'(plen); i++) gaps = {gaps, i};
        if (gaps.size() > 0) pkt_bytes[gaps[$urandom_range(gaps.size() - 1)]] =
          byte'($urandom_range(1, 255));
      end
      F_SHORT: begin
        n = $urandom_range(1, pkt_bytes.size() - 1);
        while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
      end
      F_LONG: repeat ($urandom_range(1, 6)) add_byte(byte'($urandom));
      default: ;
    endcase
  endfunction

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      while ($urandom_range(99) < send_idle) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= pkt_bytes[i];
      in_tlast <= (i == pkt_bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      predict_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, bit [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAX_VERTICES:  lim_vert = {32'd0, val};
      REG_MAX_TRIANGLES: lim_tri = {32'd0, val};
      REG_MAX_PKT_BYTES: lim_bytes = {32'd0, val};
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (record_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  // record checker
  always @(posedge clk) begin
    rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (record_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record kind=%0d data=%h", out_tuser, out_tdata);
      end else begin
        e = record_q.pop_front();
        if (out_tuser != e.kind || out_tdata[31:0] != e.index ||
            out_tdata[95:32] != e.word_a || out_tdata[159:96] != e.word_b ||
            out_tdata[223:160] != e.word_c || out_tdata[225:224] != e.status ||
            out_tlast != e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch: exp kind=%0d idx=%0d a=%h b=%h c=%h st=%0d last=%0b",
                     e.kind, e.index, e.word_a, e.word_b, e.word_c, e.status, e.last,
                     "\n                 got kind=%0d idx=%0d a=%h b=%h c=%h st=%0d last=%0b",
                     out_tuser, out_tdata[31:0], out_tdata[95:32], out_tdata[159:96],
                     out_tdata[223:160], out_tdata[225:224], out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    int r;
    fault_t flt;
    int vc;
    ref_defaults: begin
      lim_vert = 64'hFFFF_FFFF;
      lim_tri = 64'hFFFF_FFFF;
      lim_bytes = 64'd4294967288;
      packet_clear();
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed packets at reset limits
    foreach (pkt_tab[i]) begin
      build_packet(pkt_tab[i].vc, pkt_tab[i].tc, pkt_tab[i].src, pkt_tab[i].flt);
      send_packet();
      if (pkt_tab[i].chk && last_status != pkt_tab[i].st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: status exp %0d, predicted %0d", i, pkt_tab[i].st, last_status);
      end
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MAX_VERTICES, 32'hFFFF_FFFF);
          write_reg(REG_MAX_TRIANGLES, 32'hFFFF_FFFF);
          write_reg(REG_MAX_PKT_BYTES, 32'd4294967288);
          send_idle = 0;
          recv_stall = 0;
        end
        1: begin
          write_reg(REG_MAX_VERTICES, 32'd4);
          write_reg(REG_MAX_TRIANGLES, 32'd3);
          write_reg(REG_MAX_PKT_BYTES, 32'd220);
          send_idle = 85;
          recv_stall = 0;
        end
        2: begin
          write_reg(REG_MAX_VERTICES, 32'd1);
          write_reg(REG_MAX_TRIANGLES, 32'd1);
          write_reg(REG_MAX_PKT_BYTES, 32'd64);
          send_idle = 0;
          recv_stall = 85;
        end
        default: begin
          write_reg(REG_MAX_VERTICES, 32'd6);
          write_reg(REG_MAX_TRIANGLES, 32'd4);
          write_reg(REG_MAX_PKT_BYTES, 32'd400);
          send_idle = 23;
          recv_stall = 23;
        end
      endcase
      sent = 0;
      while (sent < 390) begin
        r = $urandom_range(99);
        flt = (r < 55) ? F_NONE : fault_t'($urandom_range(1, 14));
        vc = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
        build_packet(vc, $urandom_range(1, 4), $urandom_range(1), flt);
        sent += pkt_bytes.size();
        send_packet();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && record_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/msc_pkg.sv
hw/rtl/msc_core.sv
hw/rtl/msc_out_fifo.sv
hw/rtl/mesh_packet_stream_checker_unit.sv
hw/rtl/msc_checker.sv
tb/testbench.sv
